// File: sv/pfcc_pkg.sv
// Shared constants, types and the CRC-8 function of the pressure frame converter.
package pfcc_pkg;

   // Field widths of the transactions.
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int PRESSURE_W = 24;
   localparam int TEMP_W     = 15;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;

   // Frame layout and CRC-8 definition.
   localparam logic [POS_W-1:0]  FRAME_LAST = 4'd8;
   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT   = 8'hFF;

   // Byte positions inside the frame.
   localparam logic [POS_W-1:0] POS_P_HI  = 4'd0;
   localparam logic [POS_W-1:0] POS_P_LO  = 4'd1;
   localparam logic [POS_W-1:0] POS_P_CRC = 4'd2;
   localparam logic [POS_W-1:0] POS_T_HI  = 4'd3;
   localparam logic [POS_W-1:0] POS_T_LO  = 4'd4;
   localparam logic [POS_W-1:0] POS_T_CRC = 4'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUS_ERROR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PCRC_BAD  = 2'd2;

   // Pressure scaling and divider sizing.
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd120;
   localparam int                 FRAC_W      = 8;
   localparam int                 DIV_STEPS   = PRESSURE_W;
   localparam int                 DIV_CNT_W   = $clog2(DIV_STEPS);

   // Temperature conversion: -4500 + floor(17500 * raw / 65535).
   localparam int                 PROD_W       = 31;
   localparam logic [14:0]        TEMP_SPAN    = 15'd17500;
   localparam logic [WORD_W:0]    TEMP_DIVISOR = 17'd65535;
   localparam logic [TEMP_W-1:0]  TEMP_OFFSET  = 15'd4500;
   localparam logic [TEMP_W-1:0]  TEMP_ERROR   = 15'd2500;

   // One accepted byte as seen by the frame tracker.
   typedef struct packed {
      logic              accept;
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
      logic              bus_error;
   } byte_in_type;

   // Frame completion event from the frame tracker.
   typedef struct packed {
      logic                fire;
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   pressure_raw;
      logic [WORD_W-1:0]   temp_word;
      logic                temp_crc_bad;
   } frame_evt_type;

   // Divider request and result.
   typedef struct packed {
      logic                  start;
      logic [PRESSURE_W-1:0] dividend;
      logic [SCALE_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [PRESSURE_W-1:0] quotient;
   } div_rsp_type;

   // CRC-8 over one byte, MSB first, no final xor.
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: sv/pfcc_if.sv
// Handshake interfaces for the byte, result and scale register channels.
interface pfcc_req_if import pfcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;
   logic              bus_error;

   modport source (output valid, rx_byte, frame_start, bus_error, input ready);
   modport sink   (input valid, rx_byte, frame_start, bus_error, output ready);
endinterface

interface pfcc_rsp_if import pfcc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [PRESSURE_W-1:0] pressure_q8;
   logic signed [TEMP_W-1:0]     temp_centi;
   logic [STATUS_W-1:0]          status;
   logic                         temp_crc_bad;

   modport source (output valid, pressure_q8, temp_centi, status, temp_crc_bad, input ready);
   modport sink   (input valid, pressure_q8, temp_centi, status, temp_crc_bad, output ready);
endinterface

interface pfcc_csr_if import pfcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCALE_W-1:0] pressure_scale;

   modport source (output valid, pressure_scale, input ready);
   modport sink   (input valid, pressure_scale, output ready);
endinterface

// File: sv/pressure_frame_crc_convert.sv
// Top level of the pressure frame CRC check and unit conversion block.
//
// The block takes a 9-byte sensor read frame, one byte per transaction on the
// req_ channel. Bytes 0 and 1 carry a signed pressure word with its CRC-8
// (polynomial 0x31, start 0xFF) in byte 2; bytes 3 and 4 carry a temperature
// word with its CRC-8 in byte 5; bytes 6 to 8 are ignored. A set frame_start
// restarts the count and drops a partial frame; after the ninth byte the count
// wraps by itself. Bytes 0 to 7 produce nothing unless they carry a bus error.
// The result transaction of a good frame appears on rsp_ once its ninth byte is
// taken and the divide is over: the accepting edge starts the serial divider,
// which forms raw * 256 / pressure_scale one quotient bit per cycle, and the
// result register loads when the divider's done flag is seen. A bus error or
// a pressure CRC mismatch gives its result in the cycle after the byte. The block
// takes no new byte from the moment a result is due until that result
// transaction has been taken. The temperature, -4500 + floor(17500 * raw /
// 65535) in hundredths of a degree C, is worked out from a registered product
// while the divider runs. A pressure_scale of 0 acts as 1. The scale register
// is written on csr_ at any time and is always ready, but it should only change
// while the block is idle.
module pressure_frame_crc_convert import pfcc_pkg::*; (
   input logic        clock,
   input logic        reset,
   pfcc_req_if.sink   req_ch,
   pfcc_rsp_if.source rsp_ch,
   pfcc_csr_if.sink   csr_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_SEND
   } state_type;

   state_type                    state_ff, state_in;
   logic [SCALE_W-1:0]           scale_ff;
   logic                         neg_ff, neg_in;
   logic                         tbad_ff, tbad_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic signed [PRESSURE_W-1:0] pres_ff, pres_in;
   logic signed [TEMP_W-1:0]     temp_ff, temp_in;
   logic [STATUS_W-1:0]          status_ff, status_in;

   byte_in_type                  byte_in;
   frame_evt_type                evt;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;
   logic [WORD_W-1:0]            pmag;
   logic [TEMP_W-1:0]            tq0;
   logic [WORD_W:0]              tsum;
   logic [TEMP_W-1:0]            tquo;

   // Scale register; the write channel never stalls.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         scale_ff <= csr_ch.pressure_scale;
      end
   end

   // Bytes are taken only while no result is pending.
   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      byte_in.accept      = req_ch.valid && req_ch.ready;
      byte_in.rx_byte     = req_ch.rx_byte;
      byte_in.frame_start = req_ch.frame_start;
      byte_in.bus_error   = req_ch.bus_error;
   end

   pfcc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .byte_in (byte_in),
      .evt     (evt)
   );

   // The divider works on the pressure magnitude; the sign is put back at the end,
   // which gives truncation toward zero.
   always_comb begin
      pmag             = evt.pressure_raw[WORD_W-1] ? (~evt.pressure_raw + 1'b1)
                                                    : evt.pressure_raw;
      div_req.start    = evt.fire && (evt.status == STATUS_OK);
      div_req.dividend = {pmag, {FRAC_W{1'b0}}};
      div_req.divisor  = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   end

   pfcc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Division by 65535: with x = q0 * 65536 + lo the remainder against 65535 is
   // lo + q0, which stays below twice the divisor, so one compare corrects q0.
   always_comb begin
      tq0  = prod_ff[PROD_W-1:WORD_W];
      tsum = {1'b0, prod_ff[WORD_W-1:0]} + {2'b00, tq0};
      tquo = tq0 + TEMP_W'(tsum >= TEMP_DIVISOR);
   end

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      tbad_in   = tbad_ff;
      prod_in   = prod_ff;
      pres_in   = pres_ff;
      temp_in   = temp_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (evt.fire) begin
               if (evt.status == STATUS_OK) begin
                  neg_in   = evt.pressure_raw[WORD_W-1];
                  tbad_in  = evt.temp_crc_bad;
                  prod_in  = PROD_W'(TEMP_SPAN) * PROD_W'(evt.temp_word);
                  state_in = S_DIVIDE;
               end else begin
                  pres_in   = '0;
                  temp_in   = $signed(TEMP_ERROR);
                  status_in = evt.status;
                  tbad_in   = 1'b0;
                  state_in  = S_SEND;
               end
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               pres_in   = neg_ff ? $signed(-div_rsp.quotient) : $signed(div_rsp.quotient);
               temp_in   = $signed(tquo - TEMP_OFFSET);
               status_in = STATUS_OK;
               state_in  = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff    <= neg_in;
      tbad_ff   <= tbad_in;
      prod_ff   <= prod_in;
      pres_ff   <= pres_in;
      temp_ff   <= temp_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid        = (state_ff == S_SEND);
   assign rsp_ch.pressure_q8  = pres_ff;
   assign rsp_ch.temp_centi   = temp_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.temp_crc_bad = tbad_ff;

   // A pending result always blocks the byte channel.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("byte channel ready while a result is pending");

   // A bus error transaction yields its error result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.bus_error) |=>
      (rsp_ch.valid && rsp_ch.status == STATUS_BUS_ERROR))
      else $error("bus error did not produce an error result");

   // Error results carry the fixed fallback values.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != STATUS_OK) |->
      (rsp_ch.pressure_q8 == '0 && rsp_ch.temp_centi == $signed(TEMP_ERROR)
       && !rsp_ch.temp_crc_bad))
      else $error("error result without fallback values");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside the divide state");

endmodule

// File: sv/pfcc_frame.sv
// Frame tracker: byte position, running CRC-8 and captured pressure and temperature words.
module pfcc_frame import pfcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  byte_in_type   byte_in,
   output frame_evt_type evt
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] praw_ff, praw_in;
   logic [WORD_W-1:0] traw_ff, traw_in;
   logic              pok_ff, pok_in;
   logic              tok_ff, tok_in;
   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] crc_next;

   always_comb begin
      pos      = byte_in.frame_start ? POS_P_HI : pos_ff;
      crc_next = crc8_byte(crc_ff, byte_in.rx_byte);
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      praw_in  = praw_ff;
      traw_in  = traw_ff;
      pok_in   = pok_ff;
      tok_in   = tok_ff;
      if (byte_in.accept) begin
         if (byte_in.bus_error) begin
            pos_in = POS_P_HI;
            crc_in = CRC_INIT;
         end else begin
            case (pos)
               POS_P_HI: begin
                  crc_in  = crc8_byte(CRC_INIT, byte_in.rx_byte);
                  praw_in = {byte_in.rx_byte, praw_ff[BYTE_W-1:0]};
               end
               POS_P_LO: begin
                  crc_in  = crc_next;
                  praw_in = {praw_ff[WORD_W-1:BYTE_W], byte_in.rx_byte};
               end
               POS_P_CRC: pok_in = (crc_ff == byte_in.rx_byte);
               POS_T_HI: begin
                  crc_in  = crc8_byte(CRC_INIT, byte_in.rx_byte);
                  traw_in = {byte_in.rx_byte, traw_ff[BYTE_W-1:0]};
               end
               POS_T_LO: begin
                  crc_in  = crc_next;
                  traw_in = {traw_ff[WORD_W-1:BYTE_W], byte_in.rx_byte};
               end
               POS_T_CRC: tok_in = (crc_ff == byte_in.rx_byte);
               default: ;
            endcase
            if (pos < FRAME_LAST) begin
               pos_in = pos + 1'b1;
            end else begin
               pos_in = POS_P_HI;
               crc_in = CRC_INIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_P_HI;
         crc_ff  <= CRC_INIT;
         praw_ff <= '0;
         traw_ff <= '0;
         pok_ff  <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         praw_ff <= praw_in;
         traw_ff <= traw_in;
         pok_ff  <= pok_in;
         tok_ff  <= tok_in;
      end
   end

   // The ninth byte reads the flags and words captured earlier in the frame.
   always_comb begin
      evt.fire         = byte_in.accept && (byte_in.bus_error || pos == FRAME_LAST);
      evt.status       = byte_in.bus_error ? STATUS_BUS_ERROR :
                         (pok_ff ? STATUS_OK : STATUS_PCRC_BAD);
      evt.pressure_raw = praw_ff;
      evt.temp_word    = traw_ff;
      evt.temp_crc_bad = !tok_ff;
   end

endmodule

// File: sv/pfcc_div.sv
// Restoring serial divider that yields one quotient bit per cycle.
module pfcc_div import pfcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [SCALE_W-1:0]    rem_ff, rem_in;
   logic [PRESSURE_W-1:0] quo_ff, quo_in;
   logic [SCALE_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SCALE_W:0]      shifted;
   logic [SCALE_W:0]      diff;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[PRESSURE_W-1]};
      fits    = (shifted >= {1'b0, dsr_ff});
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SCALE_W-1:0] : shifted[SCALE_W-1:0];
         quo_in = {quo_ff[PRESSURE_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
